>>> hw/rtl/bfr_pkg.sv
`timescale 1ns / 1ps

package bfr_pkg;

  // Framebuffer and character cell geometry
  localparam int FB_WIDTH    = 128;
  localparam int FB_HEIGHT   = 128;
  localparam int CELL_WIDTH  = 4;
  localparam int CELL_HEIGHT = 6;

  // Cursor plus in-glyph offset, two guard bits for saturation
  localparam int COORD_W     = 18;
  localparam int FB_X_W      = $clog2(FB_WIDTH);
  localparam int FB_Y_W      = $clog2(FB_HEIGHT);
  localparam int ADDR_W      = 14;
  localparam int ADDR_FULL_W = $clog2(FB_WIDTH * FB_HEIGHT);
  localparam int ADDR_CALC_W = (ADDR_FULL_W > ADDR_W) ? ADDR_FULL_W : ADDR_W;

  localparam int GLYPH_W     = 15;
  localparam logic [GLYPH_W-1:0] FULL_BLOCK = 15'h7fff;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Result tdata layout
  localparam int OUT_ADDR_LSB  = 0;
  localparam int OUT_COLOR_LSB = 14;
  localparam int OUT_NCX_LSB   = 30;
  localparam int OUT_DATA_W    = 48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_END
  } bfr_state_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_X     = 2'd0,
    REG_ORIGIN_Y     = 2'd1,
    REG_TEXT_COLOR   = 2'd2,
    REG_DOUBLE_SCALE = 2'd3
  } bfr_reg_t;

  function automatic logic signed [15:0] sat16(input logic signed [COORD_W-1:0] v);
    logic signed [15:0] r;
    if (v > $signed(COORD_W'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -$signed(COORD_W'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // 3x5 font; bits 0..2 are the top row, bit 0 leftmost
  function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic [6:0] code);
    logic [GLYPH_W-1:0] g;
    case (code)
      7'd33:  g = 15'h2092;
      7'd34:  g = 15'h002d;
      7'd35:  g = 15'h5f7d;
      7'd36:  g = 15'h2f9f;
      7'd37:  g = 15'h52a5;
      7'd38:  g = 15'h7adb;
      7'd39:  g = 15'h0012;
      7'd40:  g = 15'h224a;
      7'd41:  g = 15'h2922;
      7'd42:  g = 15'h55d5;
      7'd43:  g = 15'h05d0;
      7'd44:  g = 15'h1400;
      7'd45:  g = 15'h01c0;
      7'd46:  g = 15'h2000;
      7'd47:  g = 15'h1494;
      7'd48:  g = 15'h7b6f;
      7'd49:  g = 15'h7493;
      7'd50:  g = 15'h73e7;
      7'd51:  g = 15'h79a7;
      7'd52:  g = 15'h49ed;
      7'd53:  g = 15'h79cf;
      7'd54:  g = 15'h7bc9;
      7'd55:  g = 15'h4927;
      7'd56:  g = 15'h7bef;
      7'd57:  g = 15'h49ef;
      7'd58:  g = 15'h0410;
      7'd59:  g = 15'h1410;
      7'd60:  g = 15'h4454;
      7'd61:  g = 15'h0e38;
      7'd62:  g = 15'h1511;
      7'd63:  g = 15'h21a7;
      7'd64:  g = 15'h636a;
      7'd65:  g = 15'h5bef;
      7'd66:  g = 15'h7aef;
      7'd67:  g = 15'h624e;
      7'd68:  g = 15'h7b6b;
      7'd69:  g = 15'h72cf;
      7'd70:  g = 15'h12cf;
      7'd71:  g = 15'h7a4e;
      7'd72:  g = 15'h5bed;
      7'd73:  g = 15'h7497;
      7'd74:  g = 15'h3497;
      7'd75:  g = 15'h5aed;
      7'd76:  g = 15'h7249;
      7'd77:  g = 15'h5b7f;
      7'd78:  g = 15'h5b6b;
      7'd79:  g = 15'h3b6e;
      7'd80:  g = 15'h13ef;
      7'd81:  g = 15'h676a;
      7'd82:  g = 15'h5aef;
      7'd83:  g = 15'h39ce;
      7'd84:  g = 15'h2497;
      7'd85:  g = 15'h6b6d;
      7'd86:  g = 15'h2b6d;
      7'd87:  g = 15'h7f6d;
      7'd88:  g = 15'h5aad;
      7'd89:  g = 15'h79ed;
      7'd90:  g = 15'h72a7;
      7'd91:  g = 15'h324b;
      7'd92:  g = 15'h4491;
      7'd93:  g = 15'h6926;
      7'd94:  g = 15'h002a;
      7'd95:  g = 15'h7000;
      7'd96:  g = 15'h0022;
      7'd97:  g = 15'h5f78;
      7'd98:  g = 15'h7ad8;
      7'd99:  g = 15'h7278;
      7'd100: g = 15'h3b58;
      7'd101: g = 15'h72f8;
      7'd102: g = 15'h12f8;
      7'd103: g = 15'h7a78;
      7'd104: g = 15'h5f68;
      7'd105: g = 15'h74b8;
      7'd106: g = 15'h34b8;
      7'd107: g = 15'h5ae8;
      7'd108: g = 15'h7248;
      7'd109: g = 15'h5bf8;
      7'd110: g = 15'h5b58;
      7'd111: g = 15'h3b70;
      7'd112: g = 15'h1f78;
      7'd113: g = 15'h6750;
      7'd114: g = 15'h5778;
      7'd115: g = 15'h3870;
      7'd116: g = 15'h24b8;
      7'd117: g = 15'h6b68;
      7'd118: g = 15'h2f68;
      7'd119: g = 15'h7f68;
      7'd120: g = 15'h5aa8;
      7'd121: g = 15'h79e8;
      7'd122: g = 15'h7338;
      7'd123: g = 15'h64d6;
      7'd124: g = 15'h2492;
      7'd125: g = 15'h3593;
      7'd126: g = 15'h03e0;
      7'd127: g = 15'h0550;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> hw/rtl/bitmap_font_text_renderer.sv
`timescale 1ns / 1ps

// Character generator, 3x5 bitmap font, writing into a framebuffer.
// Input stream: one character transaction at a time; tdata carries the
// character code, tuser flags the start of a string (cursor back to origin).
// Result stream: one transaction per lit, on-screen pixel (tuser high) with
// its framebuffer address and colour, then an end-of-character transaction
// (tuser low, tlast high) carrying the cursor column after the character.
// A newline (code 10) gives only the end transaction.
// Timing: the glyph is walked by one shared coordinate/address unit, one
// glyph position per cycle while the output register is free: 15 steps at
// 1x, 60 steps at 2x (four sub-pixels per glyph pixel), then the end
// transaction. in_tready drops once a character is accepted and rises again
// after the end transaction is loaded, so one character is done before the next.
// A single output register holds each result; while the receiver stalls the
// walk stops at the current position and resumes when the register frees.
// Configuration goes through the APB port (origin_x, origin_y, text_color,
// double_scale at 0x0, 0x4, 0x8, 0xC) and should only be written when idle.
// Reset (synchronous, active low) restores register defaults, clears the
// cursor to (0,0) and drops any pending result.

module bitmap_font_text_renderer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [0:0]  in_tuser,   // [0] start_string
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [bfr_pkg::OUT_DATA_W-1:0] out_tdata, // [13:0] pixel_addr,
                                                    // [29:14] pixel_color,
                                                    // [45:30] next_cursor_x
  output logic [0:0]  out_tuser,  // [0] is_pixel
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bfr_pkg::*;

  // configuration registers
  logic signed [15:0] origin_x_r, origin_y_r;
  logic [15:0]        text_color_r;
  logic               double_scale_r;
  bfr_reg_t           cfg_idx;
  logic               cfg_wr;

  // sequencer
  bfr_state_t         state_r, state_nxt;
  logic signed [15:0] cursor_col_r, cursor_col_nxt;
  logic signed [15:0] cursor_row_r, cursor_row_nxt;
  logic [GLYPH_W-1:0] glyph_r, glyph_nxt;
  logic [2:0]         row_r, row_nxt;
  logic [1:0]         col_r, col_nxt;
  logic [1:0]         sub_r, sub_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_pix_r, out_pix_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [15:0]        out_color_r, out_color_nxt;
  logic signed [15:0] out_ncx_r, out_ncx_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc, out_free, step_go, last_sub, last_pix;
  logic signed [15:0] base_col, base_row;
  logic [2:0]         off_x;
  logic [3:0]         off_y;
  logic signed [COORD_W-1:0] pix_x, pix_y;
  logic signed [COORD_W-1:0] cell_adv, line_adv;
  logic               in_fb;
  logic [ADDR_CALC_W-1:0] addr_full;

  // ---------------- APB ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = bfr_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      text_color_r   <= 16'hffff;
      double_scale_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X:     origin_x_r     <= cfg_pwdata[15:0];
        REG_ORIGIN_Y:     origin_y_r     <= cfg_pwdata[15:0];
        REG_TEXT_COLOR:   text_color_r   <= cfg_pwdata[15:0];
        REG_DOUBLE_SCALE: double_scale_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X:     cfg_prdata = {16'h0, origin_x_r};
      REG_ORIGIN_Y:     cfg_prdata = {16'h0, origin_y_r};
      REG_TEXT_COLOR:   cfg_prdata = {16'h0, text_color_r};
      REG_DOUBLE_SCALE: cfg_prdata = {31'h0, double_scale_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- handshakes ----------------
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign step_go   = (state_r == ST_DRAW) & out_free;
  assign last_sub  = ~double_scale_r | (sub_r == 2'd3);
  assign last_pix  = (row_r == 3'd4) & (col_r == 2'd2);

  // ---------------- shared coordinate / address unit ----------------
  // at 2x, sub[0] picks the right half and sub[1] the lower half of a block
  assign off_x = double_scale_r ? {col_r, sub_r[0]} : {1'b0, col_r};
  assign off_y = double_scale_r ? {row_r, sub_r[1]} : {1'b0, row_r};
  assign pix_x = COORD_W'(cursor_col_r) + $signed(COORD_W'(off_x));
  assign pix_y = COORD_W'(cursor_row_r) + $signed(COORD_W'(off_y));
  assign in_fb = ~pix_x[COORD_W-1] & (pix_x < $signed(COORD_W'(FB_WIDTH))) &
                 ~pix_y[COORD_W-1] & (pix_y < $signed(COORD_W'(FB_HEIGHT)));
  assign addr_full = ADDR_CALC_W'(pix_y[FB_Y_W-1:0]) * ADDR_CALC_W'(FB_WIDTH) +
                     ADDR_CALC_W'(pix_x[FB_X_W-1:0]);

  assign cell_adv = double_scale_r ? COORD_W'(2 * CELL_WIDTH)  : COORD_W'(CELL_WIDTH);
  assign line_adv = double_scale_r ? COORD_W'(2 * CELL_HEIGHT) : COORD_W'(CELL_HEIGHT);
  assign base_col = in_tuser[0] ? origin_x_r : cursor_col_r;
  assign base_row = in_tuser[0] ? origin_y_r : cursor_row_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = (in_tdata == NEWLINE_CODE) ? ST_END : ST_DRAW;
      end
      ST_DRAW: if (step_go && last_sub && last_pix) begin
        state_nxt = ST_END;
      end
      ST_END: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath and outputs ----------------
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    glyph_nxt      = glyph_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    sub_nxt        = sub_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_pix_nxt    = out_pix_r;
    out_addr_nxt   = out_addr_r;
    out_color_nxt  = out_color_r;
    out_ncx_nxt    = out_ncx_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: if (in_acc) begin
        row_nxt   = '0;
        col_nxt   = '0;
        sub_nxt   = '0;
        glyph_nxt = in_tdata[7] ? FULL_BLOCK : glyph_lookup(in_tdata[6:0]);
        if (in_tdata == NEWLINE_CODE) begin
          cursor_col_nxt = origin_x_r;
          cursor_row_nxt = sat16(COORD_W'(base_row) + line_adv);
        end else begin
          cursor_col_nxt = base_col;
          cursor_row_nxt = base_row;
        end
      end
      ST_DRAW: if (step_go) begin
        if (glyph_r[0] && in_fb) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = 1'b1;
          out_addr_nxt  = addr_full[ADDR_W-1:0];
          out_color_nxt = text_color_r;
          out_ncx_nxt   = '0;
          out_last_nxt  = 1'b0;
        end
        if (!last_sub) begin
          sub_nxt = sub_r + 2'd1;
        end else begin
          sub_nxt   = '0;
          glyph_nxt = glyph_r >> 1;
          if (col_r == 2'd2) begin
            col_nxt = '0;
            row_nxt = row_r + 3'd1;
          end else begin
            col_nxt = col_r + 2'd1;
          end
          if (last_pix) begin
            cursor_col_nxt = sat16(COORD_W'(cursor_col_r) + cell_adv);
          end
        end
      end
      ST_END: if (out_free) begin
        out_valid_nxt = 1'b1;
        out_pix_nxt   = 1'b0;
        out_addr_nxt  = '0;
        out_color_nxt = '0;
        out_ncx_nxt   = cursor_col_r;
        out_last_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r     <= glyph_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    sub_r       <= sub_nxt;
    out_pix_r   <= out_pix_nxt;
    out_addr_r  <= out_addr_nxt;
    out_color_r <= out_color_nxt;
    out_ncx_r   <= out_ncx_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_pix_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_ncx_r, out_color_r, out_addr_r};

endmodule

>>> hw/rtl/bfr_checker.sv
`timescale 1ns / 1ps

module bfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [bfr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);
  import bfr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a pixel write is never the final record of a character
  a_pix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast)
    else $error("pixel record marked last");

  // the end record always closes the character
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("end record without tlast");

  // pixel records carry no cursor column
  a_pix_ncx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[OUT_NCX_LSB +: 16] == 16'h0)
    else $error("pixel record with non-zero cursor field");

  // one character at a time: busy right after a character is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after a transaction");

endmodule

bind bitmap_font_text_renderer bfr_checker u_bfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> sim/tb.sv
`timescale 1ns / 1ps

// Character generator bench: directed glyph/scale/limit cases, then random text runs.
// Every accepted character transaction is rendered by a local predictor into a queue
// of framebuffer writes; every result transaction is checked against the oldest entry.

module tb;
  import bfr_pkg::*;

  localparam int RANDOM_ITEMS = 192;
  localparam int CALM_TAIL    = 40;      // final random items run with no idling
  localparam int SETTLE       = 4;       // idle cycles before touching registers
  localparam int DRAIN_WAIT   = 70;      // a little over one 2x character
  localparam int CYCLE_LIMIT  = 1000000;

  // One result transaction as it leaves the block
  typedef struct packed {
    logic        is_pixel;
    logic [13:0] addr;
    logic [15:0] colour;
    logic [15:0] next_x;
    logic        last;
  } fb_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state: registers as last written, plus the text cursor
  logic signed [15:0] org_x = 16'sd0;
  logic signed [15:0] org_y = 16'sd0;
  logic [15:0]        ink   = 16'hffff;
  logic               dbl   = 1'b0;
  logic signed [15:0] cur_col = 16'sd0;
  logic signed [15:0] cur_row = 16'sd0;

  fb_rec_t fb_writes_due[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      sink_hold   = 0;
  bit      calm        = 1'b0;   // set: neither side idles

  // 3x5 font, bits 0..2 = top row, bit 0 = leftmost column
  logic [14:0] glyphs [128] = '{
    15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000,
    15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000,
    15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000,
    15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000,
    15'h0000, 15'h2092, 15'h002d, 15'h5f7d, 15'h2f9f, 15'h52a5, 15'h7adb, 15'h0012,
    15'h224a, 15'h2922, 15'h55d5, 15'h05d0, 15'h1400, 15'h01c0, 15'h2000, 15'h1494,
    15'h7b6f, 15'h7493, 15'h73e7, 15'h79a7, 15'h49ed, 15'h79cf, 15'h7bc9, 15'h4927,
    15'h7bef, 15'h49ef, 15'h0410, 15'h1410, 15'h4454, 15'h0e38, 15'h1511, 15'h21a7,
    15'h636a, 15'h5bef, 15'h7aef, 15'h624e, 15'h7b6b, 15'h72cf, 15'h12cf, 15'h7a4e,
    15'h5bed, 15'h7497, 15'h3497, 15'h5aed, 15'h7249, 15'h5b7f, 15'h5b6b, 15'h3b6e,
    15'h13ef, 15'h676a, 15'h5aef, 15'h39ce, 15'h2497, 15'h6b6d, 15'h2b6d, 15'h7f6d,
    15'h5aad, 15'h79ed, 15'h72a7, 15'h324b, 15'h4491, 15'h6926, 15'h002a, 15'h7000,
    15'h0022, 15'h5f78, 15'h7ad8, 15'h7278, 15'h3b58, 15'h72f8, 15'h12f8, 15'h7a78,
    15'h5f68, 15'h74b8, 15'h34b8, 15'h5ae8, 15'h7248, 15'h5bf8, 15'h5b58, 15'h3b70,
    15'h1f78, 15'h6750, 15'h5778, 15'h3870, 15'h24b8, 15'h6b68, 15'h2f68, 15'h7f68,
    15'h5aa8, 15'h79e8, 15'h7338, 15'h64d6, 15'h2492, 15'h3593, 15'h03e0, 15'h0550
  };

  bitmap_font_text_renderer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Watchdog: the slowest legal run stays well inside this limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // One framebuffer write, dropped when off-screen
  function automatic void plot(input int x, input int y);
    fb_rec_t r;
    int      a;
    if (x < 0 || x >= FB_WIDTH || y < 0 || y >= FB_HEIGHT) return;
    a          = y * FB_WIDTH + x;
    r.is_pixel = 1'b1;
    r.addr     = a[13:0];          // wide framebuffers wrap to 14 bits
    r.colour   = ink;
    r.next_x   = '0;
    r.last     = 1'b0;
    fb_writes_due.push_back(r);
  endfunction

  function automatic void push_end_record();
    fb_rec_t r;
    r.is_pixel = 1'b0;
    r.addr     = '0;
    r.colour   = '0;
    r.next_x   = cur_col;
    r.last     = 1'b1;
    fb_writes_due.push_back(r);
  endfunction

  // Works out every write one accepted character causes, and moves the cursor
  function automatic void render_char(input logic [7:0] code, input logic restart);
    int          sc, px, py;
    logic [14:0] g;
    sc = dbl ? 2 : 1;
    if (restart) begin
      cur_col = org_x;
      cur_row = org_y;
    end
    if (code == NEWLINE_CODE) begin
      cur_col = org_x;
      cur_row = clamp16(int'(cur_row) + CELL_HEIGHT * sc);
      push_end_record();
      return;
    end
    g = code[7] ? FULL_BLOCK : glyphs[code[6:0]];
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (g[r*3 + c]) begin
          px = int'(cur_col) + c * sc;
          py = int'(cur_row) + r * sc;
          plot(px, py);
          if (sc == 2) begin
            plot(px + 1, py);
            plot(px, py + 1);
            plot(px + 1, py + 1);
          end
        end
      end
    end
    cur_col = clamp16(int'(cur_col) + CELL_WIDTH * sc);
    push_end_record();
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------

  // Random stall bursts, none while calm
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_hold  <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fb_rec_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.is_pixel = out_tuser[0];
      got.addr     = out_tdata[OUT_ADDR_LSB +: 14];
      got.colour   = out_tdata[OUT_COLOR_LSB +: 16];
      got.next_x   = out_tdata[OUT_NCX_LSB +: 16];
      got.last     = out_tlast;
      if (fb_writes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: unexpected transaction pix=%0b addr=%0d colour=%h nx=%0d last=%0b",
                   cycle_count, got.is_pixel, got.addr, got.colour,
                   $signed(got.next_x), got.last);
      end else begin
        want = fb_writes_due.pop_front();
        if (got.is_pixel !== want.is_pixel || got.addr !== want.addr ||
            got.colour !== want.colour || got.next_x !== want.next_x ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("cycle %0d: mismatch", cycle_count);
            $display("  expected pix=%0b addr=%0d colour=%h nx=%0d last=%0b",
                     want.is_pixel, want.addr, want.colour, $signed(want.next_x), want.last);
            $display("  actual   pix=%0b addr=%0d colour=%h nx=%0d last=%0b",
                     got.is_pixel, got.addr, got.colour, $signed(got.next_x), got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Register write: setup phase then access phase; pready is honoured anyway
  task automatic cfg_write(input bfr_reg_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ORIGIN_X:     org_x = val[15:0];
      REG_ORIGIN_Y:     org_y = val[15:0];
      REG_TEXT_COLOR:   ink   = val[15:0];
      REG_DOUBLE_SCALE: dbl   = val[0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // One character transaction; tvalid stays up into the next call unless a gap is drawn
  task automatic send_char(input logic [7:0] code, input logic restart);
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    render_char(code, restart);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Registers may only change once the block has emptied out
  task automatic await_idle();
    in_tvalid <= 1'b0;
    while (fb_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_text_mode(input logic [15:0] ox, input logic [15:0] oy,
                               input logic [15:0] colour, input logic two_x);
    await_idle();
    cfg_write(REG_ORIGIN_X, {16'h0000, ox});
    cfg_write(REG_ORIGIN_Y, {16'h0000, oy});
    cfg_write(REG_TEXT_COLOR, {16'h0000, colour});
    cfg_write(REG_DOUBLE_SCALE, {31'd0, two_x});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: blank control codes, space, edges of the ROM, full block, newline
  task automatic test_glyph_set();
    send_char("A", 1'b1);
    send_char(8'd0, 1'b0);
    send_char(8'd31, 1'b0);
    send_char(8'd32, 1'b0);
    send_char(8'd33, 1'b0);
    send_char(8'd127, 1'b0);
    send_char(8'd128, 1'b0);
    send_char(8'd255, 1'b0);
    send_char(NEWLINE_CODE, 1'b0);
    send_char("W", 1'b0);
  endtask

  // 2x blocks clipped at the right/bottom edges, then at the top/left
  task automatic test_double_scale();
    set_text_mode(16'd120, 16'd118, 16'h0000, 1'b1);
    send_char("#", 1'b1);
    send_char(8'd255, 1'b0);
    send_char("8", 1'b0);
    send_char(NEWLINE_CODE, 1'b0);   // row 130: wholly below the framebuffer
    send_char("W", 1'b0);
    set_text_mode(16'hfffd, 16'hfffe, 16'hf81f, 1'b1);
    send_char(8'd128, 1'b1);
    send_char("M", 1'b0);
  endtask

  // Cursor saturation at the positive limit, and origins at both extremes
  task automatic test_cursor_limits();
    set_text_mode(16'd32760, 16'd32765, 16'h07e0, 1'b0);
    send_char("X", 1'b1);
    send_char("Y", 1'b0);
    send_char("Z", 1'b0);             // column pinned at 32767
    send_char(NEWLINE_CODE, 1'b0);
    send_char(NEWLINE_CODE, 1'b0);    // row pinned at 32767
    set_text_mode(16'h8000, 16'h7fff, 16'hffff, 1'b0);
    send_char("A", 1'b1);
    send_char(NEWLINE_CODE, 1'b0);
    set_text_mode(16'h7fff, 16'h8000, 16'h1234, 1'b1);
    send_char(8'd255, 1'b1);
  endtask

  // Mostly near the visible area, sometimes anywhere in the 16-bit range
  function automatic logic [15:0] pick_origin(input int span);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, span + 7) - 8);
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return NEWLINE_CODE;
    if (r < 85) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // Runs of text, each under fresh settings; upper write-data bits are noise
  task automatic test_random_text();
    int sent, run_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      await_idle();
      calm = (sent >= RANDOM_ITEMS - CALM_TAIL);
      cfg_write(REG_ORIGIN_X, {16'($urandom), pick_origin(FB_WIDTH)});
      cfg_write(REG_ORIGIN_Y, {16'($urandom), pick_origin(FB_HEIGHT)});
      cfg_write(REG_TEXT_COLOR, $urandom);
      cfg_write(REG_DOUBLE_SCALE, {$urandom} & 32'hffff_fffe | 32'($urandom_range(0, 2) == 0));
      run_len = $urandom_range(8, 30);
      for (int i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
        send_char(pick_code(), i == 0 || $urandom_range(0, 19) == 0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_glyph_set();
    test_double_scale();
    test_cursor_limits();
    test_random_text();

    // Drain, then give the block time to show any stray transaction
    in_tvalid <= 1'b0;
    while (fb_writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fb_writes_due.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bfr_pkg.sv
hw/rtl/bitmap_font_text_renderer.sv
hw/rtl/bfr_checker.sv
sim/tb.sv
